// File: sv/min_max_bucket_decimator_assert.svh
// Assertion macros for the min/max bucket decimator.
// Define NO_ASSERTIONS to compile them out.
`ifndef MIN_MAX_BUCKET_DECIMATOR_ASSERT_SVH
`define MIN_MAX_BUCKET_DECIMATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define MMBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define MMBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MMBD_ASSERT_IMP(label, ante, cons, msg)

`define MMBD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: sv/mmbd_pkg.sv
package mmbd_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 20;
    localparam int PIXEL_BITS  = 12;
    localparam int WIDTH_BITS  = 16;
    localparam int COUNT_BITS  = 13;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_COUNT = 1'd1;

    localparam logic [WIDTH_BITS-1:0] BUCKET_WIDTH_RESET = 16'd8;
    localparam logic [COUNT_BITS-1:0] BUCKET_COUNT_RESET = 13'd1024;
    localparam logic [COUNT_BITS-1:0] MAX_BUCKETS        = 13'd4096;

    // Bucket queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          sample_first;
        logic                          sample_last;
    } sample_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]         point_index;
        logic signed [SAMPLE_BITS-1:0] point_value;
        logic [PIXEL_BITS-1:0]         pixel_number;
        logic                          pair_last;
    } point_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] bucket_width;
        logic [COUNT_BITS-1:0] bucket_count;
    } cfg_t;

    // One closed bucket: its extremes and its number.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] min_value;
        logic [INDEX_BITS-1:0]         min_index;
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic [INDEX_BITS-1:0]         max_index;
        logic [PIXEL_BITS-1:0]         pixel;
    } bucket_t;

endpackage

// File: sv/mmbd_front.sv
module mmbd_front
    import mmbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    accept,
    input  sample_t sample,
    output logic    bucket_push,
    output bucket_t bucket
);

    logic [WIDTH_BITS-1:0]         ibc_reg, ibc_next;
    logic [PIXEL_BITS-1:0]         bn_reg, bn_next;
    logic [INDEX_BITS-1:0]         ri_reg, ri_next;
    logic signed [SAMPLE_BITS-1:0] min_value_reg, min_value_next;
    logic [INDEX_BITS-1:0]         min_index_reg, min_index_next;
    logic signed [SAMPLE_BITS-1:0] max_value_reg, max_value_next;
    logic [INDEX_BITS-1:0]         max_index_reg, max_index_next;
    logic                          done_reg, done_next;

    logic [WIDTH_BITS-1:0] width_eff;
    logic [COUNT_BITS-1:0] count_eff;
    logic [WIDTH_BITS-1:0] ibc_base;
    logic [WIDTH_BITS-1:0] ibc_inc;
    logic [PIXEL_BITS-1:0] bn_base;
    logic [PIXEL_BITS-1:0] bn_inc;
    logic [INDEX_BITS-1:0] ri_base;
    logic                  done_now;
    logic                  taking;
    logic                  init;
    logic                  close;

    // Clamp the configured width and count to their working ranges.
    always_comb
    begin
        width_eff = (cfg.bucket_width == '0) ? WIDTH_BITS'(1) : cfg.bucket_width;
        if (cfg.bucket_count == '0)
        begin
            count_eff = COUNT_BITS'(1);
        end
        else if (cfg.bucket_count > MAX_BUCKETS)
        begin
            count_eff = MAX_BUCKETS;
        end
        else
        begin
            count_eff = cfg.bucket_count;
        end
    end

    // A first sample restarts the record before it is taken.
    assign ibc_base = sample.sample_first ? '0 : ibc_reg;
    assign bn_base  = sample.sample_first ? '0 : bn_reg;
    assign ri_base  = sample.sample_first ? '0 : ri_reg;
    assign done_now = (sample.sample_first ? 1'b0 : done_reg)
                      | ({1'b0, bn_base} >= count_eff);

    assign taking  = accept & ~done_now;
    assign init    = (ibc_base == '0);
    assign ibc_inc = (ibc_base == '1) ? ibc_base : ibc_base + WIDTH_BITS'(1);
    assign close   = (ibc_inc >= width_eff) | sample.sample_last;
    assign bn_inc  = bn_base + PIXEL_BITS'(1);

    // Running extremes; the earliest sample wins a tie.
    always_comb
    begin
        min_value_next = min_value_reg;
        min_index_next = min_index_reg;
        max_value_next = max_value_reg;
        max_index_next = max_index_reg;
        if (taking && (init || (sample.sample_value < min_value_reg)))
        begin
            min_value_next = sample.sample_value;
            min_index_next = ri_base;
        end
        if (taking && (init || (sample.sample_value > max_value_reg)))
        begin
            max_value_next = sample.sample_value;
            max_index_next = ri_base;
        end
    end

    // Record counters and the finished flag.
    always_comb
    begin
        ibc_next  = ibc_reg;
        bn_next   = bn_reg;
        ri_next   = ri_reg;
        done_next = done_reg;
        if (accept)
        begin
            ibc_next  = ibc_base;
            bn_next   = bn_base;
            ri_next   = ri_base;
            done_next = done_now;
            if (taking)
            begin
                ri_next  = ri_base + INDEX_BITS'(1);
                ibc_next = close ? '0 : ibc_inc;
                if (close)
                begin
                    bn_next   = bn_inc;
                    done_next = sample.sample_last | (bn_inc == '0)
                                | ({1'b0, bn_inc} >= count_eff);
                end
            end
        end
    end

    // Hand a closed bucket to the queue.
    assign bucket_push      = taking & close;
    assign bucket.min_value = min_value_next;
    assign bucket.min_index = min_index_next;
    assign bucket.max_value = max_value_next;
    assign bucket.max_index = max_index_next;
    assign bucket.pixel     = bn_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ibc_reg       <= '0;
            bn_reg        <= '0;
            ri_reg        <= '0;
            min_value_reg <= '0;
            min_index_reg <= '0;
            max_value_reg <= '0;
            max_index_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            ibc_reg       <= ibc_next;
            bn_reg        <= bn_next;
            ri_reg        <= ri_next;
            min_value_reg <= min_value_next;
            min_index_reg <= min_index_next;
            max_value_reg <= max_value_next;
            max_index_reg <= max_index_next;
            done_reg      <= done_next;
        end
    end

endmodule

// File: sv/mmbd_queue.sv
module mmbd_queue
    import mmbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bucket_t push_data,
    output logic    full,
    input  logic    pop,
    output bucket_t head,
    output logic    empty
);

    bucket_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_BITS + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/mmbd_back.sv
module mmbd_back
    import mmbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bucket_t head,
    input  logic    head_empty,
    output logic    head_pop,
    output point_t  point,
    output logic    point_valid,
    input  logic    point_take
);

    logic   phase_reg, phase_next;
    logic   valid_reg, valid_next;
    point_t out_reg, out_next;
    logic   load;
    logic   min_first;
    point_t min_point;
    point_t max_point;

    // The lower index goes first; the maximum on equal indices.
    assign min_first = (head.min_index < head.max_index);

    assign min_point.point_index  = head.min_index;
    assign min_point.point_value  = head.min_value;
    assign min_point.pixel_number = head.pixel;
    assign min_point.pair_last    = phase_reg;
    assign max_point.point_index  = head.max_index;
    assign max_point.point_value  = head.max_value;
    assign max_point.pixel_number = head.pixel;
    assign max_point.pair_last    = phase_reg;

    // The output register reloads when empty or being taken.
    assign load     = ~valid_reg | point_take;
    assign head_pop = load & ~head_empty & phase_reg;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (load)
        begin
            valid_next = ~head_empty;
            if (!head_empty)
            begin
                out_next   = (min_first ^ phase_reg) ? min_point : max_point;
                phase_next = ~phase_reg;
            end
        end
    end

    assign point       = out_reg;
    assign point_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: sv/min_max_bucket_decimator.sv
// Throughput: one sample per cycle while the queue is not full; each closed bucket yields two
// points, one per cycle while they are popped, so a stream of one-sample buckets stalls the input.
// Path: a closing bucket is written into a four-entry bucket queue, then its first point
// into the output register; the second point is loaded there as the first is taken.
// Reset: asynchronous, active low; clears the counters, queue and output, loads
// bucket width 8 and bucket count 1024, and opens a record at index 0.
module min_max_bucket_decimator
    import mmbd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  sample_t                   sample,
    input  logic                      push,
    output logic                      full,
    output point_t                    point,
    output logic                      empty,
    input  logic                      pop
);

`include "min_max_bucket_decimator_assert.svh"

    logic [WIDTH_BITS-1:0] bucket_width_reg, bucket_width_next;
    logic [COUNT_BITS-1:0] bucket_count_reg, bucket_count_next;
    cfg_t                  cfg;
    logic                  accept;
    logic                  q_push;
    bucket_t               q_in;
    logic                  q_full;
    logic                  q_pop;
    bucket_t               q_head;
    logic                  q_empty;
    logic                  point_valid;

    // Configuration register writes.
    always_comb
    begin
        bucket_width_next = bucket_width_reg;
        bucket_count_next = bucket_count_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BUCKET_WIDTH: bucket_width_next = cfg_data[WIDTH_BITS-1:0];
                REG_BUCKET_COUNT: bucket_count_next = cfg_data[COUNT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_width_reg <= BUCKET_WIDTH_RESET;
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end
        else
        begin
            bucket_width_reg <= bucket_width_next;
            bucket_count_reg <= bucket_count_next;
        end
    end

    assign cfg.bucket_width = bucket_width_reg;
    assign cfg.bucket_count = bucket_count_reg;

    // An item is taken whenever the queue has room for a closing bucket.
    assign full   = q_full;
    assign accept = push & ~q_full;
    assign empty  = ~point_valid;

    mmbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .sample      (sample),
        .bucket_push (q_push),
        .bucket      (q_in)
    );

    mmbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    mmbd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_empty  (q_empty),
        .head_pop    (q_pop),
        .point       (point),
        .point_valid (point_valid),
        .point_take  (pop)
    );

    // A closing bucket always finds room in the queue.
    `MMBD_ASSERT_IMP(a_push_room, q_push, !q_full, "bucket pushed into a full queue")

    // The back end only retires a bucket that is there.
    `MMBD_ASSERT_IMP(a_pop_present, q_pop, !q_empty, "bucket popped from an empty queue")

    // Taking the first point of a pair brings its partner in the next cycle.
    `MMBD_ASSERT_NXT(a_pair_follows, !empty && pop && !point.pair_last,
        !empty && point.pair_last && (point.pixel_number == $past(point.pixel_number)),
        "second point of a pair did not follow the first")

endmodule

// File: sim/min_max_bucket_decimator_checker.sv
`timescale 1ns / 1ps

// Watches the register port and both queue sides of the decimator, predicts the
// extreme points of every closed bucket and compares them with what the block pops.
module min_max_bucket_decimator_checker
    import mmbd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  sample_t                   sample,
    input  logic                      push,
    input  logic                      full,
    input  point_t                    point,
    input  logic                      empty,
    input  logic                      pop,
    output int                        mismatches,
    output int                        points_due
);

    // Register copies.
    logic [WIDTH_BITS-1:0]         width_reg;
    logic [COUNT_BITS-1:0]         count_reg;

    // Bucket tracking state.
    logic [WIDTH_BITS-1:0]         fill;
    logic [PIXEL_BITS-1:0]         bucket_no;
    logic [INDEX_BITS-1:0]         rec_idx;
    logic signed [SAMPLE_BITS-1:0] lo_val;
    logic signed [SAMPLE_BITS-1:0] hi_val;
    logic [INDEX_BITS-1:0]         lo_idx;
    logic [INDEX_BITS-1:0]         hi_idx;
    logic                          rec_done;

    point_t                        pending_extremes[$];

    // Fold one accepted sample into the open bucket and queue the pair it closes.
    task automatic fold_sample(input sample_t s);
        logic [WIDTH_BITS-1:0]         span;
        logic [COUNT_BITS-1:0]         limit;
        logic signed [SAMPLE_BITS-1:0] v;
        point_t                        lead;
        point_t                        trail;
        v = s.sample_value;
        span = (width_reg == '0) ? WIDTH_BITS'(1) : width_reg;
        limit = (count_reg == '0) ? COUNT_BITS'(1) : count_reg;
        if (limit > MAX_BUCKETS)
            limit = MAX_BUCKETS;

        if (s.sample_first)
        begin
            fill = '0;
            bucket_no = '0;
            rec_idx = '0;
            rec_done = 1'b0;
        end
        // A lowered bucket count can finish the record before this sample.
        if (!rec_done && bucket_no >= limit)
            rec_done = 1'b1;
        if (rec_done)
            return;

        // The earliest sample wins on ties, so only strict comparisons update.
        if (fill == '0)
        begin
            lo_val = v;
            hi_val = v;
            lo_idx = rec_idx;
            hi_idx = rec_idx;
        end
        else
        begin
            if (v < lo_val)
            begin
                lo_val = v;
                lo_idx = rec_idx;
            end
            if (v > hi_val)
            begin
                hi_val = v;
                hi_idx = rec_idx;
            end
        end
        rec_idx = rec_idx + 1'b1;
        if (fill != '1)
            fill = fill + 1'b1;

        if (fill < span && !s.sample_last)
            return;

        // Lower index first; equal indices put the maximum first.
        if (lo_idx < hi_idx)
        begin
            lead  = '{lo_idx, lo_val, bucket_no, 1'b0};
            trail = '{hi_idx, hi_val, bucket_no, 1'b1};
        end
        else
        begin
            lead  = '{hi_idx, hi_val, bucket_no, 1'b0};
            trail = '{lo_idx, lo_val, bucket_no, 1'b1};
        end
        pending_extremes.push_back(lead);
        pending_extremes.push_back(trail);

        fill = '0;
        bucket_no = bucket_no + 1'b1;
        if (s.sample_last || bucket_no == '0 || bucket_no >= limit)
            rec_done = 1'b1;
    endtask

    // Print one differing field, with a cap so a broken block cannot flood the log.
    task automatic show_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (mismatches < 40)
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    endtask

    // Compare a popped point with the oldest predicted one.
    task automatic check_point(input point_t got);
        point_t want;
        bit     bad;
        if (pending_extremes.size() == 0)
        begin
            if (mismatches < 40)
                $display("%0t ns: expected no point, actual index %0h value %0h pixel %0h",
                         $time, got.point_index, got.point_value, got.pixel_number);
            mismatches++;
            return;
        end
        want = pending_extremes.pop_front();
        bad = 1'b0;
        if (got.point_index !== want.point_index)
        begin
            show_field("point_index", 32'(want.point_index), 32'(got.point_index));
            bad = 1'b1;
        end
        if (got.point_value !== want.point_value)
        begin
            show_field("point_value", 32'(want.point_value), 32'(got.point_value));
            bad = 1'b1;
        end
        if (got.pixel_number !== want.pixel_number)
        begin
            show_field("pixel_number", 32'(want.pixel_number), 32'(got.pixel_number));
            bad = 1'b1;
        end
        if (got.pair_last !== want.pair_last)
        begin
            show_field("pair_last", 32'(want.pair_last), 32'(got.pair_last));
            bad = 1'b1;
        end
        if (bad)
            mismatches++;
    endtask

    // Register writes come first, then the accepted sample, then the popped point.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = BUCKET_WIDTH_RESET;
            count_reg = BUCKET_COUNT_RESET;
            fill = '0;
            bucket_no = '0;
            rec_idx = '0;
            lo_val = '0;
            hi_val = '0;
            lo_idx = '0;
            hi_idx = '0;
            rec_done = 1'b0;
            pending_extremes.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BUCKET_WIDTH: width_reg = cfg_data[WIDTH_BITS-1:0];
                    REG_BUCKET_COUNT: count_reg = cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                fold_sample(sample);
            if (pop && !empty)
                check_point(point);
        end
        points_due = pending_extremes.size();
    end

endmodule

// File: sim/min_max_bucket_decimator_test.sv
`timescale 1ns / 1ps

module min_max_bucket_decimator_test;
    import mmbd_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    sample_t                   sample;
    logic                      push;
    logic                      full;
    point_t                    point;
    logic                      empty;
    logic                      pop;

    int                        mismatches;
    int                        points_due;
    int                        send_idle_pct;
    int                        recv_idle_pct;
    logic                      hold_req;

    min_max_bucket_decimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .push      (push),
        .full      (full),
        .point     (point),
        .empty     (empty),
        .pop       (pop)
    );

    min_max_bucket_decimator_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .push       (push),
        .full       (full),
        .point      (point),
        .empty      (empty),
        .pop        (pop),
        .mismatches (mismatches),
        .points_due (points_due)
    );

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Give up long after the slowest correct run would have finished.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Point side: random idling, plus one long hold-off once it is requested.
    initial
    begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                stall_left = 300;
                hold_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one sample, after random idle cycles, and hold it until the block takes it.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v,
                               input logic f, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        sample <= '{sample_value: v, sample_first: f, sample_last: l};
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering, let every predicted point come out, then let the pipeline settle.
    task automatic wait_idle();
        push <= 1'b0;
        @(negedge clk);
        while (points_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles.
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] width_val,
                              input logic [CFG_DATA_BITS-1:0] count_val);
        cfg_write <= 1'b1;
        cfg_index <= REG_BUCKET_WIDTH;
        cfg_data <= width_val;
        @(negedge clk);
        cfg_index <= REG_BUCKET_COUNT;
        cfg_data <= count_val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Amplitudes: the extremes, a narrow band that makes ties, or anything.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3, 4: return SAMPLE_BITS'($urandom_range(6) - 3);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly whole records with random content, some stray flags in between.
    task automatic run_records(input int n_items);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_sample(pick_value(), $urandom_range(7) == 0, $urandom_range(7) == 0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(120, 30) : $urandom_range(30, 1);
                for (k = 0; k < len; k++)
                    send_sample(pick_value(), k == 0, k == len - 1 && $urandom_range(4) != 0);
                sent += len;
            end
        end
    endtask

    initial
    begin
        int mode;
        int sub;
        logic [CFG_DATA_BITS-1:0] width_val;
        logic [CFG_DATA_BITS-1:0] count_val;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_BUCKET_WIDTH;
        cfg_data = '0;
        sample = '0;
        push = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Extremes and ties: the maximum comes first on the first bucket, and the
        // later equal samples must not replace the earlier ones.
        set_config(16'd4, 16'd3);
        send_sample(16'sh7FFF, 1'b1, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        // A flat bucket: both extremes on one index.
        repeat (4) send_sample(16'sd5, 1'b0, 1'b0);
        // Last sample closes a partial bucket; the next ones are ignored.
        send_sample(-16'sd1, 1'b0, 1'b0);
        send_sample(16'sd100, 1'b0, 1'b1);
        send_sample(16'sd9, 1'b0, 1'b0);
        send_sample(16'sd9, 1'b0, 1'b0);
        // One-sample record.
        send_sample(16'sd7, 1'b1, 1'b1);
        // Minimum before maximum.
        send_sample(-16'sd5, 1'b1, 1'b0);
        send_sample(16'sd10, 1'b0, 1'b0);
        send_sample(16'sd2, 1'b0, 1'b1);

        // Record ends when the bucket count is reached.
        wait_idle();
        set_config(16'd1, 16'd2);
        send_sample(16'sd1, 1'b1, 1'b0);
        send_sample(16'sd2, 1'b0, 1'b0);
        send_sample(16'sd3, 1'b0, 1'b0);

        // Zero width and zero count act as one.
        wait_idle();
        set_config(16'd0, 16'd0);
        send_sample(16'sd4, 1'b1, 1'b0);
        send_sample(16'sd5, 1'b0, 1'b0);

        // Narrower width mid-bucket closes it on the next sample; a count at or below
        // the current bucket number finishes the record at once.
        wait_idle();
        set_config(16'd8, 16'd1024);
        send_sample(16'sd1, 1'b1, 1'b0);
        send_sample(16'sd2, 1'b0, 1'b0);
        send_sample(16'sd3, 1'b0, 1'b0);
        wait_idle();
        set_config(16'd2, 16'd1024);
        send_sample(-16'sd7, 1'b0, 1'b0);
        wait_idle();
        set_config(16'd2, 16'd1);
        send_sample(16'sd11, 1'b0, 1'b0);

        // Random records under three idling patterns and changing settings.
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 51 : 0;
            recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 25 : 0;
            for (sub = 0; sub < 5; sub++)
            begin
                case ($urandom_range(9))
                    0: width_val = 16'd0;
                    1: width_val = 16'd1;
                    2: width_val = 16'hFFFF;
                    3: width_val = CFG_DATA_BITS'($urandom_range(400, 100));
                    default: width_val = CFG_DATA_BITS'($urandom_range(12, 1));
                endcase
                case ($urandom_range(7))
                    0: count_val = 16'd0;
                    1: count_val = 16'd4096;
                    2: count_val = 16'hFFFF;
                    3: count_val = 16'd5000;
                    4: count_val = 16'd1;
                    default: count_val = CFG_DATA_BITS'($urandom_range(10, 2));
                endcase
                wait_idle();
                if (mode == 2 && sub == 0)
                begin
                    // Hold the point side off so the block fills and stalls its input.
                    set_config(16'd1, 16'd4096);
                    @(posedge clk);
                    hold_req = 1'b1;
                    @(negedge clk);
                end
                else
                    set_config(width_val, count_val);
                run_records(28);
            end
        end

        wait_idle();
        repeat (16) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/mmbd_pkg.sv
sv/mmbd_front.sv
sv/mmbd_queue.sv
sv/mmbd_back.sv
sv/min_max_bucket_decimator.sv
sim/min_max_bucket_decimator_checker.sv
sim/min_max_bucket_decimator_test.sv
